// ----- sv/assert_macros.svh -----
// Assertion macros used by the deframer top level.
// Depends on nothing; the including scope supplies clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PLD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pkt_line_deframer assertion failed");

// Next-cycle implication, checked outside reset.
`define PLD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pkt_line_deframer assertion failed");

`endif

// ----- sv/pld_pkg.sv -----
// Shared types, codes and the hex digit decoder for the pkt-line deframer.
// Depends on nothing.
package pld_pkg;

  localparam logic [2:0] KIND_BYTE     = 3'd0;
  localparam logic [2:0] KIND_FLUSH    = 3'd1;
  localparam logic [2:0] KIND_DELIM    = 3'd2;
  localparam logic [2:0] KIND_RESP_END = 3'd3;
  localparam logic [2:0] KIND_EMPTY    = 3'd4;
  localparam logic [2:0] KIND_EOS      = 3'd5;
  localparam logic [2:0] KIND_ERROR    = 3'd6;

  localparam logic [2:0] CAUSE_NONE     = 3'd0;
  localparam logic [2:0] CAUSE_HEX      = 3'd1;
  localparam logic [2:0] CAUSE_RESERVED = 3'd2;
  localparam logic [2:0] CAUSE_TRUNC    = 3'd3;
  localparam logic [2:0] CAUSE_CHANNEL  = 3'd4;

  localparam logic [1:0] CHAN_NONE     = 2'd0;
  localparam logic [1:0] CHAN_DATA     = 2'd1;
  localparam logic [1:0] CHAN_PROGRESS = 2'd2;

  localparam logic       ITEM_BYTE = 1'b0;
  localparam logic       ITEM_EOS  = 1'b1;

  localparam logic [1:0] LAST_DIGIT = 2'd3;
  localparam logic [15:0] HDR_LEN   = 16'd4;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] stream_byte;
  } pld_item_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic [7:0] payload_byte;
    logic [1:0] channel;
    logic       last_of_packet;
    logic [2:0] error_cause;
  } pld_result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } pld_hex_t;

  function automatic pld_hex_t hex_decode(input logic [7:0] c);
    pld_hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= "0" && c <= "9") begin
      h.val = 4'(c - 8'h30);
    end else if (c >= "a" && c <= "f") begin
      h.val = 4'(c - 8'h57);
    end else if (c >= "A" && c <= "F") begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// ----- sv/pld_in_if.sv -----
// Input word channel of the pkt-line deframer: valid, ready and one stream item.
// Depends on nothing.
interface pld_in_if;
  logic       valid;
  logic       ready;
  logic       item_kind;
  logic [7:0] stream_byte;

  modport source (output valid, output item_kind, output stream_byte, input ready);
  modport sink   (input valid, input item_kind, input stream_byte, output ready);
endinterface

// ----- sv/pld_out_if.sv -----
// Result word channel of the pkt-line deframer: valid, ready and one result.
// Depends on nothing.
interface pld_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] result_kind;
  logic [7:0] payload_byte;
  logic [1:0] channel;
  logic       last_of_packet;
  logic [2:0] error_cause;

  modport source (output valid, output result_kind, output payload_byte, output channel,
                  output last_of_packet, output error_cause, input ready);
  modport sink   (input valid, input result_kind, input payload_byte, input channel,
                  input last_of_packet, input error_cause, output ready);
endinterface

// ----- sv/pld_in_stage.sv -----
// Input register of the deframer: holds one accepted word until the parser takes it.
// Depends on pld_pkg and pld_in_if.
module pld_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  pld_in_if.sink             in_ch,
  input  logic               take_i,
  output pld_pkg::pld_item_t item_o,
  output logic               item_valid_o
);

  logic               valid_r;
  pld_pkg::pld_item_t item_r;

  assign in_ch.ready  = !valid_r || take_i;
  assign item_o       = item_r;
  assign item_valid_o = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.item_kind   <= in_ch.item_kind;
      item_r.stream_byte <= in_ch.stream_byte;
    end
  end

endmodule

// ----- sv/pld_parse.sv -----
// Framing FSM: decodes length header, walks payload; one word a cycle unless stalled.
// Depends on pld_pkg.
module pld_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 sideband_enable_i,
  input  pld_pkg::pld_item_t   item_i,
  input  logic                 item_valid_i,
  input  logic                 load_ready_i,
  output logic                 take_o,
  output pld_pkg::pld_result_t res_o,
  output logic                 res_valid_o
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_ERROR   = 2'd2
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  digit_count_r, digit_count_nxt;
  logic [11:0] length_accum_r, length_accum_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic        channel_pending_r, channel_pending_nxt;
  logic [1:0]  current_channel_r, current_channel_nxt;
  logic [2:0]  sticky_cause_r, sticky_cause_nxt;

  pld_pkg::pld_hex_t hex;
  logic [15:0]       len;
  logic [15:0]       left_dec;
  logic [7:0]        b;

  assign take_o   = item_valid_i && load_ready_i;
  assign b        = item_i.stream_byte;
  assign hex      = pld_pkg::hex_decode(b);
  assign len      = {length_accum_r, hex.val};
  assign left_dec = bytes_left_r - 16'd1;

  always_comb begin
    phase_nxt           = phase_r;
    digit_count_nxt     = digit_count_r;
    length_accum_nxt    = length_accum_r;
    bytes_left_nxt      = bytes_left_r;
    channel_pending_nxt = channel_pending_r;
    current_channel_nxt = current_channel_r;
    sticky_cause_nxt    = sticky_cause_r;
    res_valid_o         = 1'b0;
    res_o               = '0;

    case (phase_r)
      PH_HEADER, PH_PAYLOAD: begin
        if (item_i.item_kind == pld_pkg::ITEM_EOS) begin
          res_valid_o = 1'b1;
          if (phase_r == PH_HEADER && digit_count_r == 2'd0) begin
            res_o.result_kind = pld_pkg::KIND_EOS;
          end else begin
            res_o.result_kind = pld_pkg::KIND_ERROR;
            res_o.error_cause = pld_pkg::CAUSE_TRUNC;
            phase_nxt         = PH_ERROR;
            sticky_cause_nxt  = pld_pkg::CAUSE_TRUNC;
          end
        end else if (phase_r == PH_HEADER) begin
          if (!hex.ok) begin
            res_valid_o       = 1'b1;
            res_o.result_kind = pld_pkg::KIND_ERROR;
            res_o.error_cause = pld_pkg::CAUSE_HEX;
            phase_nxt         = PH_ERROR;
            sticky_cause_nxt  = pld_pkg::CAUSE_HEX;
          end else if (digit_count_r != pld_pkg::LAST_DIGIT) begin
            length_accum_nxt = {length_accum_r[7:0], hex.val};
            digit_count_nxt  = digit_count_r + 2'd1;
          end else begin
            digit_count_nxt     = 2'd0;
            length_accum_nxt    = '0;
            current_channel_nxt = pld_pkg::CHAN_NONE;
            channel_pending_nxt = 1'b0;
            res_valid_o         = 1'b1;
            if (len == 16'd0) begin
              res_o.result_kind = pld_pkg::KIND_FLUSH;
            end else if (len == 16'd1) begin
              res_o.result_kind = pld_pkg::KIND_DELIM;
            end else if (len == 16'd2) begin
              res_o.result_kind = pld_pkg::KIND_RESP_END;
            end else if (len == 16'd3) begin
              res_o.result_kind = pld_pkg::KIND_ERROR;
              res_o.error_cause = pld_pkg::CAUSE_RESERVED;
              phase_nxt         = PH_ERROR;
              sticky_cause_nxt  = pld_pkg::CAUSE_RESERVED;
            end else if (len == pld_pkg::HDR_LEN) begin
              res_o.result_kind = pld_pkg::KIND_EMPTY;
            end else begin
              res_valid_o         = 1'b0;
              bytes_left_nxt      = len - pld_pkg::HDR_LEN;
              channel_pending_nxt = sideband_enable_i;
              phase_nxt           = PH_PAYLOAD;
            end
          end
        end else begin
          // The byte count is never zero while in the payload phase.
          bytes_left_nxt = left_dec;
          if (channel_pending_r) begin
            channel_pending_nxt = 1'b0;
            if (b != {6'd0, pld_pkg::CHAN_DATA} && b != {6'd0, pld_pkg::CHAN_PROGRESS}) begin
              res_valid_o       = 1'b1;
              res_o.result_kind = pld_pkg::KIND_ERROR;
              res_o.error_cause = pld_pkg::CAUSE_CHANNEL;
              phase_nxt         = PH_ERROR;
              sticky_cause_nxt  = pld_pkg::CAUSE_CHANNEL;
            end else begin
              current_channel_nxt = b[1:0];
              if (left_dec == 16'd0) begin
                phase_nxt         = PH_HEADER;
                res_valid_o       = 1'b1;
                res_o.result_kind = pld_pkg::KIND_EMPTY;
                res_o.channel     = b[1:0];
              end
            end
          end else begin
            res_valid_o          = 1'b1;
            res_o.result_kind    = pld_pkg::KIND_BYTE;
            res_o.payload_byte   = b;
            res_o.channel        = current_channel_r;
            res_o.last_of_packet = (left_dec == 16'd0);
            if (left_dec == 16'd0) begin
              phase_nxt = PH_HEADER;
            end
          end
        end
      end
      default: begin
        res_valid_o       = 1'b1;
        res_o.result_kind = pld_pkg::KIND_ERROR;
        res_o.error_cause = sticky_cause_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= PH_HEADER;
      digit_count_r     <= 2'd0;
      length_accum_r    <= '0;
      bytes_left_r      <= '0;
      channel_pending_r <= 1'b0;
      current_channel_r <= pld_pkg::CHAN_NONE;
      sticky_cause_r    <= pld_pkg::CAUSE_NONE;
    end else if (take_o) begin
      phase_r           <= phase_nxt;
      digit_count_r     <= digit_count_nxt;
      length_accum_r    <= length_accum_nxt;
      bytes_left_r      <= bytes_left_nxt;
      channel_pending_r <= channel_pending_nxt;
      current_channel_r <= current_channel_nxt;
      sticky_cause_r    <= sticky_cause_nxt;
    end
  end

endmodule

// ----- sv/pld_out_stage.sv -----
// Result register of the deframer: holds one result word until the sink takes it.
// Depends on pld_pkg and pld_out_if.
module pld_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load_i,
  input  logic                 res_valid_i,
  input  pld_pkg::pld_result_t res_i,
  output logic                 load_ready_o,
  pld_out_if.source            out_ch
);

  logic                 valid_r;
  pld_pkg::pld_result_t res_r;

  assign load_ready_o          = !valid_r || out_ch.ready;
  assign out_ch.valid          = valid_r;
  assign out_ch.result_kind    = res_r.result_kind;
  assign out_ch.payload_byte   = res_r.payload_byte;
  assign out_ch.channel        = res_r.channel;
  assign out_ch.last_of_packet = res_r.last_of_packet;
  assign out_ch.error_cause    = res_r.error_cause;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_i) begin
      valid_r <= res_valid_i;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i && res_valid_i) begin
      res_r <= res_i;
    end
  end

endmodule

// ----- sv/pkt_line_deframer.sv -----
// Top level of the pkt-line deframer: input register, framing parser, result register.
// Depends on pld_pkg, pld_in_if, pld_out_if, the three stage modules and assert_macros.svh.
//
//   port          dir  kind          contents
//   in_ch         in   valid/ready   item_kind, stream_byte
//   out_ch        out  valid/ready   result_kind, payload_byte, channel, last, cause
//   cfg_wr_en/_data in  write only   sideband_enable
//
// One word is accepted per cycle unless the input stalls; its result, if any, is offered
// from the result register, after the input register and the parser.
// Reset is synchronous and active low; no clearing pass follows.
// A stalled result stalls the input only once both registers hold a word.
`include "assert_macros.svh"

module pkt_line_deframer (
  input  logic     clk,
  input  logic     rst_n,
  pld_in_if.sink   in_ch,
  pld_out_if.source out_ch,
  input  logic     cfg_wr_en,
  input  logic     cfg_wr_data
);

  logic                 sideband_r;
  pld_pkg::pld_item_t   item;
  logic                 item_valid;
  logic                 take;
  logic                 load_ready;
  pld_pkg::pld_result_t res;
  logic                 res_valid;
  logic                 out_err;
  logic                 out_byte;
  logic                 no_cause;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sideband_r <= 1'b0;
    end else if (cfg_wr_en) begin
      sideband_r <= cfg_wr_data;
    end
  end

  pld_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .take_i       (take),
    .item_o       (item),
    .item_valid_o (item_valid)
  );

  pld_parse u_parse (
    .clk               (clk),
    .rst_n             (rst_n),
    .sideband_enable_i (sideband_r),
    .item_i            (item),
    .item_valid_i      (item_valid),
    .load_ready_i      (load_ready),
    .take_o            (take),
    .res_o             (res),
    .res_valid_o       (res_valid)
  );

  pld_out_stage u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .load_i       (take),
    .res_valid_i  (res_valid),
    .res_i        (res),
    .load_ready_o (load_ready),
    .out_ch       (out_ch)
  );

  assign out_err  = out_ch.result_kind == pld_pkg::KIND_ERROR;
  assign out_byte = out_ch.result_kind == pld_pkg::KIND_BYTE;
  assign no_cause = out_ch.error_cause == pld_pkg::CAUSE_NONE;

  `PLD_ASSERT_IMP(a_in_stall_only_when_full, !in_ch.ready, out_ch.valid && !out_ch.ready)
  `PLD_ASSERT_IMP(a_cause_only_on_error, out_ch.valid && !out_err, no_cause)
  `PLD_ASSERT_IMP(a_error_has_cause, out_ch.valid && out_err, !no_cause)
  `PLD_ASSERT_IMP(a_last_only_on_byte, out_ch.valid && out_ch.last_of_packet, out_byte)
  `PLD_ASSERT_NXT(a_error_is_sticky, out_ch.valid && out_err, !out_ch.valid || out_err)

endmodule

// ----- verif/pkt_line_deframer_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for pkt_line_deframer: random-gap valid/ready traffic on both channels.
// Depends on pld_pkg, pld_in_if, pld_out_if and the deframer RTL.
module pkt_line_deframer_test;

  localparam int unsigned HOLD_CYCLES = 250;

  typedef enum logic [1:0] {SCAN_HEADER, SCAN_PAYLOAD, SCAN_ERROR} scan_phase_t;
  typedef enum {IDLE_NORMAL, IDLE_FAST, IDLE_NONE} idle_mode_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;

  pld_in_if in_ch ();
  pld_out_if out_ch ();

  pkt_line_deframer uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #6 clk = ~clk;

  pld_pkg::pld_item_t pending_words[$];
  pld_pkg::pld_result_t expected_results[$];

  scan_phase_t scan_phase;
  logic [1:0] digits_seen;
  logic [15:0] len_accum;
  logic [15:0] bytes_left;
  logic chan_pending;
  logic [1:0] cur_chan;
  logic [2:0] sticky_cause;
  logic sideband_on;

  idle_mode_t idle_mode = IDLE_NORMAL;
  logic hold_out;
  logic hold_req = 1'b0;
  int unsigned err_count = 0;
  int unsigned words_sent = 0;
  int unsigned results_seen = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;

  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    case (idle_mode)
      IDLE_NONE: return 0;
      IDLE_FAST: return (r < 85) ? 0 : 1;
      default: begin
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
      end
    endcase
  endfunction

  // Bit 4 flags a valid hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    return 5'd0;
  endfunction

  function automatic bit trip_error(input logic [2:0] cause, output pld_pkg::pld_result_t res);
    scan_phase = SCAN_ERROR;
    sticky_cause = cause;
    res = '0;
    res.result_kind = pld_pkg::KIND_ERROR;
    res.error_cause = cause;
    return 1'b1;
  endfunction

  function automatic bit deframe_step(input pld_pkg::pld_item_t word,
                                      output pld_pkg::pld_result_t res);
    logic [4:0] nib;
    logic [15:0] len;
    res = '0;
    if (scan_phase != SCAN_HEADER && scan_phase != SCAN_PAYLOAD) begin
      res.result_kind = pld_pkg::KIND_ERROR;
      res.error_cause = sticky_cause;
      return 1'b1;
    end
    if (word.item_kind == pld_pkg::ITEM_EOS) begin
      if (scan_phase == SCAN_HEADER && digits_seen == 2'd0) begin
        res.result_kind = pld_pkg::KIND_EOS;
        return 1'b1;
      end
      return trip_error(pld_pkg::CAUSE_TRUNC, res);
    end
    if (scan_phase == SCAN_HEADER) begin
      nib = hex_nibble(word.stream_byte);
      if (!nib[4]) return trip_error(pld_pkg::CAUSE_HEX, res);
      len_accum = {len_accum[11:0], nib[3:0]};
      if (digits_seen != pld_pkg::LAST_DIGIT) begin
        digits_seen++;
        return 1'b0;
      end
      len = len_accum;
      digits_seen = 2'd0;
      len_accum = 16'd0;
      cur_chan = pld_pkg::CHAN_NONE;
      chan_pending = 1'b0;
      case (len)
        16'd0: res.result_kind = pld_pkg::KIND_FLUSH;
        16'd1: res.result_kind = pld_pkg::KIND_DELIM;
        16'd2: res.result_kind = pld_pkg::KIND_RESP_END;
        16'd3: return trip_error(pld_pkg::CAUSE_RESERVED, res);
        pld_pkg::HDR_LEN: res.result_kind = pld_pkg::KIND_EMPTY;
        default: begin
          bytes_left = len - pld_pkg::HDR_LEN;
          chan_pending = sideband_on;
          scan_phase = SCAN_PAYLOAD;
          return 1'b0;
        end
      endcase
      return 1'b1;
    end
    if (bytes_left != 16'd0) bytes_left--;
    if (chan_pending) begin
      chan_pending = 1'b0;
      if (word.stream_byte != {6'd0, pld_pkg::CHAN_DATA} &&
          word.stream_byte != {6'd0, pld_pkg::CHAN_PROGRESS})
        return trip_error(pld_pkg::CAUSE_CHANNEL, res);
      cur_chan = word.stream_byte[1:0];
      if (bytes_left == 16'd0) begin
        scan_phase = SCAN_HEADER;
        res.result_kind = pld_pkg::KIND_EMPTY;
        res.channel = cur_chan;
        return 1'b1;
      end
      return 1'b0;
    end
    res.result_kind = pld_pkg::KIND_BYTE;
    res.payload_byte = word.stream_byte;
    res.channel = cur_chan;
    if (bytes_left == 16'd0) begin
      scan_phase = SCAN_HEADER;
      res.last_of_packet = 1'b1;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    pld_pkg::pld_item_t offered;
    pld_pkg::pld_result_t want;
    logic busy;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      busy = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        offered.item_kind = in_ch.item_kind;
        offered.stream_byte = in_ch.stream_byte;
        if (deframe_step(offered, want)) expected_results.push_back(want);
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_words.size() != 0) begin
          offered = pending_words.pop_front();
          in_ch.item_kind <= offered.item_kind;
          in_ch.stream_byte <= offered.stream_byte;
          busy = 1'b1;
          gap_left = gap_len();
        end
      end
      in_ch.valid <= busy;
    end
  end

  always @(posedge clk) begin
    pld_pkg::pld_result_t got;
    pld_pkg::pld_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.result_kind = out_ch.result_kind;
        got.payload_byte = out_ch.payload_byte;
        got.channel = out_ch.channel;
        got.last_of_packet = out_ch.last_of_packet;
        got.error_cause = out_ch.error_cause;
        results_seen++;
        if (expected_results.size() == 0) begin
          note_error($sformatf("unexpected result: kind %0d byte %02h chan %0d last %0d cause %0d",
                               got.result_kind, got.payload_byte, got.channel,
                               got.last_of_packet, got.error_cause));
        end else begin
          want = expected_results.pop_front();
          if (got.result_kind !== want.result_kind || got.payload_byte !== want.payload_byte ||
              got.channel !== want.channel || got.last_of_packet !== want.last_of_packet ||
              got.error_cause !== want.error_cause) begin
            note_error($sformatf({"result %0d: expected kind %0d byte %02h chan %0d last %0d ",
                                  "cause %0d, got kind %0d byte %02h chan %0d last %0d cause %0d"},
                                 results_seen, want.result_kind, want.payload_byte, want.channel,
                                 want.last_of_packet, want.error_cause, got.result_kind,
                                 got.payload_byte, got.channel, got.last_of_packet,
                                 got.error_cause));
          end
        end
        stall_left = gap_len();
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_ch.ready <= !hold_out && stall_left == 0;
    end
  end

  // The long receiver hold-off runs on its own once requested.
  initial begin
    hold_out = 1'b0;
    while (!hold_req) @(posedge clk);
    hold_out <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_out <= 1'b0;
  end

  initial begin
    #(15_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic push_word(input logic kind, input logic [7:0] b);
    pld_pkg::pld_item_t w;
    w.item_kind = kind;
    w.stream_byte = b;
    pending_words.push_back(w);
    words_sent++;
  endtask

  task automatic push_header(input logic [15:0] len);
    logic [3:0] n;
    for (int i = 3; i >= 0; i--) begin
      n = len[i*4 +: 4];
      if (n < 4'd10) push_word(pld_pkg::ITEM_BYTE, "0" + 8'(n));
      else push_word(pld_pkg::ITEM_BYTE, ($urandom_range(0, 1) ? "A" : "a") + 8'(n) - 8'd10);
    end
  endtask

  task automatic push_packet(input logic [15:0] len);
    push_header(len);
    for (int i = 0; i < int'(len) - 4; i++) begin
      if (i == 0 && sideband_on) push_word(pld_pkg::ITEM_BYTE, 8'($urandom_range(1, 2)));
      else push_word(pld_pkg::ITEM_BYTE, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic push_frame();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) push_header(16'd0);
    else if (r < 14) push_header(16'd1);
    else if (r < 20) push_header(16'd2);
    else if (r < 28) push_header(pld_pkg::HDR_LEN);
    else if (r < 34) push_word(pld_pkg::ITEM_EOS, 8'($urandom_range(0, 255)));
    else if (r < 85) push_packet(16'(5 + $urandom_range(0, 20)));
    else push_packet(16'(5 + $urandom_range(21, 100)));
  endtask

  task automatic run_batch(input int unsigned count);
    int unsigned start;
    start = words_sent;
    while (words_sent - start < count) push_frame();
  endtask

  // The block is idle once no word is queued or offered and no result is owed;
  // the task then waits on for header digits still in the pipeline.
  task automatic settle();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_ch.valid || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_sideband(input logic value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sideband_on = value;
  endtask

  initial begin
    logic [2:0] tail_cause;
    logic [7:0] bad;
    logic [4:0] nib;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.item_kind = pld_pkg::ITEM_BYTE;
    in_ch.stream_byte = 8'd0;
    out_ch.ready = 1'b0;
    scan_phase = SCAN_HEADER;
    digits_seen = 2'd0;
    len_accum = 16'd0;
    bytes_left = 16'd0;
    chan_pending = 1'b0;
    cur_chan = pld_pkg::CHAN_NONE;
    sticky_cause = pld_pkg::CAUSE_NONE;
    sideband_on = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    write_sideband(1'b0);
    push_header(16'd0);
    push_header(16'd1);
    push_header(16'd2);
    push_header(pld_pkg::HDR_LEN);
    push_word(pld_pkg::ITEM_EOS, 8'hFF);
    push_packet(16'd6);
    settle();

    write_sideband(1'b1);
    run_batch(80);
    hold_req = 1'b1;
    settle();

    write_sideband(1'b0);
    idle_mode = IDLE_NONE;
    run_batch(30);
    settle();
    idle_mode = IDLE_NORMAL;
    run_batch(50);
    settle();

    // One long packet, sent with short gaps only.
    write_sideband(1'b1);
    idle_mode = IDLE_FAST;
    push_packet(16'h002E);
    settle();
    idle_mode = IDLE_NORMAL;

    write_sideband(1'($urandom_range(0, 1)));
    run_batch(60);
    settle();

    // Errors stick until reset, so exactly one cause closes the run.
    tail_cause = 3'(pld_pkg::CAUSE_HEX + $urandom_range(0, 3));
    case (tail_cause)
      pld_pkg::CAUSE_HEX: begin
        repeat ($urandom_range(0, 3))
          push_word(pld_pkg::ITEM_BYTE, 8'("0" + $urandom_range(0, 9)));
        do begin
          bad = 8'($urandom_range(0, 255));
          nib = hex_nibble(bad);
        end while (nib[4]);
        push_word(pld_pkg::ITEM_BYTE, bad);
      end
      pld_pkg::CAUSE_RESERVED: push_header(16'd3);
      pld_pkg::CAUSE_TRUNC: begin
        if ($urandom_range(0, 1)) begin
          repeat ($urandom_range(1, 3)) push_word(pld_pkg::ITEM_BYTE, "0");
        end else begin
          push_header(16'd12);
          if (sideband_on) push_word(pld_pkg::ITEM_BYTE, {6'd0, pld_pkg::CHAN_DATA});
          repeat ($urandom_range(0, 6))
            push_word(pld_pkg::ITEM_BYTE, 8'($urandom_range(0, 255)));
        end
        push_word(pld_pkg::ITEM_EOS, 8'($urandom_range(0, 255)));
      end
      default: begin
        tail_cause = pld_pkg::CAUSE_CHANNEL;
        if (!sideband_on) write_sideband(1'b1);
        push_header(16'(5 + $urandom_range(0, 5)));
        bad = 8'($urandom_range(0, 253));
        if (bad != 8'd0) bad = bad + 8'd2;
        push_word(pld_pkg::ITEM_BYTE, bad);
      end
    endcase
    repeat (10) push_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    settle();
    repeat (8) @(posedge clk);

    $display("Sent %0d stream words and checked %0d results, with sideband on and off,",
             words_sent, results_seen);
    $display("a long packet, a long output stall, and sticky error cause %0d at the end.",
             tail_cause);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
